// ===== rtl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg
// Types, constants and round functions shared by the HMAC-SHA-256 engine.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int unsigned KeyWords = 8;
	localparam logic [60:0] CntMax = {61{1'b1}};
	localparam logic [31:0] Ipad4 = 32'h36363636;
	localparam logic [31:0] Opad4 = 32'h5c5c5c5c;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       byte_present;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [63:0] mac_word_0;
		logic [63:0] mac_word_1;
		logic [63:0] mac_word_2;
		logic [63:0] mac_word_3;
	} out_item_t;

	// block source selection for a compression
	typedef enum logic [1:0] {
		SRC_BUF,
		SRC_IPAD,
		SRC_OPAD,
		SRC_DIGEST
	} blk_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IKEY,
		ST_ABSORB,
		ST_MSGBLK,
		ST_PAD,
		ST_PAD1,
		ST_LEN,
		ST_OKEY,
		ST_OUTER,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic     start;     // begin compression
		blk_src_t src;
		logic     reset_cv;  // load initial hash values
		logic     put_byte;  // write in_byte at position
		logic     put_pad;   // write 0x80 and clear rest
		logic     clr_buf;
		logic     put_len;
		logic     save_dig;
		logic     cnt_inc;
		logic     cnt_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic        busy;
		logic [60:0] cnt;
	} dp_sts_t;

	localparam logic [31:0] Iv [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] Rc [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== rtl/hse_datapath.sv =====
// ----------------------------------------------------------------------------
// hse_datapath
// Block buffer, byte counter, chain value and one-round-per-cycle compressor.
// ----------------------------------------------------------------------------
module hse_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hse_pkg::dp_cmd_t     cmd,
	input  logic [7:0]           in_byte,
	input  logic [511:0]         key,
	output hse_pkg::dp_sts_t     sts,
	output hse_pkg::out_item_t   mac
);

	logic [31:0] buf_q [16];
	logic [31:0] w_q   [16];
	logic [31:0] r_q   [8];
	logic [31:0] cv_q  [8];
	logic [31:0] dig_q [8];
	logic [60:0] cnt_q;
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic [31:0] blk   [16];
	logic [31:0] w_new, w_cur, t1, t2, e, a;
	logic [5:0]  pos;
	logic [3:0]  widx;
	logic [4:0]  sh;
	logic [63:0] bits;

	assign pos  = cnt_q[5:0];
	assign widx = pos[5:2];
	assign sh   = {~pos[1:0], 3'b000};
	assign bits = {cnt_q + 61'd64, 3'b000};

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			unique case (cmd.src)
				hse_pkg::SRC_IPAD: blk[i] = (i[0] ? key[511-64*(i/2)-32 -: 32]
					: key[511-64*(i/2) -: 32]) ^ hse_pkg::Ipad4;
				hse_pkg::SRC_OPAD: blk[i] = (i[0] ? key[511-64*(i/2)-32 -: 32]
					: key[511-64*(i/2) -: 32]) ^ hse_pkg::Opad4;
				hse_pkg::SRC_DIGEST: blk[i] = (i < 8) ? dig_q[i[2:0]] :
					(i == 8) ? 32'h80000000 : (i == 15) ? 32'd768 : 32'd0;
				default: blk[i] = buf_q[i];
			endcase
		end
	end

	assign w_cur = w_q[0];
	assign w_new = (hse_pkg::rotr(w_q[14], 17) ^ hse_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10))
		+ w_q[9] + (hse_pkg::rotr(w_q[1], 7) ^ hse_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3))
		+ w_q[0];
	assign e  = r_q[4];
	assign a  = r_q[0];
	assign t1 = r_q[7] + (hse_pkg::rotr(e, 6) ^ hse_pkg::rotr(e, 11) ^ hse_pkg::rotr(e, 25))
		+ ((e & r_q[5]) ^ (~e & r_q[6])) + hse_pkg::Rc[rnd_q] + w_cur;
	assign t2 = (hse_pkg::rotr(a, 2) ^ hse_pkg::rotr(a, 13) ^ hse_pkg::rotr(a, 22))
		+ ((a & r_q[1]) ^ (a & r_q[2]) ^ (r_q[1] & r_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			cnt_q  <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= hse_pkg::Iv[i];
		end else begin
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 61'd1;
			if (cmd.reset_cv) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= hse_pkg::Iv[i];
			end
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					cv_q[0] <= cv_q[0] + t1 + t2;
					cv_q[1] <= cv_q[1] + r_q[0];
					cv_q[2] <= cv_q[2] + r_q[1];
					cv_q[3] <= cv_q[3] + r_q[2];
					cv_q[4] <= cv_q[4] + r_q[3] + t1;
					cv_q[5] <= cv_q[5] + r_q[4];
					cv_q[6] <= cv_q[6] + r_q[5];
					cv_q[7] <= cv_q[7] + r_q[6];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
			for (int i = 0; i < 8; i++) r_q[i] <= cv_q[i];
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4];
			r_q[4] <= r_q[3] + t1;
			r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0];
			r_q[0] <= t1 + t2;
		end
		if (cmd.put_byte)
			buf_q[widx] <= (buf_q[widx] & ~(32'hff << sh)) | ({24'd0, in_byte} << sh);
		if (cmd.put_pad) begin
			for (int i = 0; i < 16; i++) begin
				if (i > widx) buf_q[i] <= '0;
			end
			buf_q[widx] <= (buf_q[widx] & ~(32'hffffffff >> {pos[1:0], 3'b000}))
				| (32'h80 << sh);
		end
		if (cmd.clr_buf) begin
			for (int i = 0; i < 16; i++) buf_q[i] <= '0;
		end
		if (cmd.put_len) begin
			buf_q[14] <= bits[63:32];
			buf_q[15] <= bits[31:0];
		end
		if (cmd.save_dig) begin
			for (int i = 0; i < 8; i++) dig_q[i] <= cv_q[i];
		end
	end

	assign sts.busy = busy_q;
	assign sts.cnt  = cnt_q;
	assign mac = {cv_q[0], cv_q[1], cv_q[2], cv_q[3], cv_q[4], cv_q[5], cv_q[6], cv_q[7]};

	a_rnd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> (rnd_q == 6'd0) || busy_q || $stable(rnd_q))
		else $error("round counter moved while idle");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && rnd_q == 6'd63 && !cmd.start |=> !busy_q)
		else $error("compression overran 64 rounds");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc && !cmd.cnt_clr |=> cnt_q == $past(cnt_q) + 61'd1)
		else $error("byte count step wrong");

endmodule

// ===== rtl/hse_ctrl.sv =====
// ----------------------------------------------------------------------------
// hse_ctrl
// Sequencer for key blocks, message blocks, padding and output handshake.
// ----------------------------------------------------------------------------
module hse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hse_pkg::in_item_t    in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  hse_pkg::dp_sts_t     sts,
	output hse_pkg::dp_cmd_t     cmd
);

	hse_pkg::state_t state_q, state_d;
	logic kdone_q, kdone_d, last_q, last_d;
	logic [5:0] pos;

	assign pos = sts.cnt[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hse_pkg::ST_IDLE;
			kdone_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kdone_q <= kdone_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kdone_d = kdone_q;
		last_d  = last_q;
		cmd = '0;
		cmd.src = hse_pkg::SRC_BUF;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			hse_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!kdone_q) begin
						cmd.start = 1'b1;
						cmd.src = hse_pkg::SRC_IPAD;
						kdone_d = 1'b1;
						state_d = hse_pkg::ST_IKEY;
					end else begin
						in_ready = 1'b1;
						last_d = in_item.last_byte;
						if (in_item.byte_present && sts.cnt != hse_pkg::CntMax) begin
							cmd.put_byte = 1'b1;
							cmd.cnt_inc = 1'b1;
							state_d = (pos == 6'd63) ? hse_pkg::ST_MSGBLK
								: (in_item.last_byte ? hse_pkg::ST_PAD : hse_pkg::ST_IDLE);
						end else if (in_item.last_byte) begin
							state_d = hse_pkg::ST_PAD;
						end
					end
				end
			end
			hse_pkg::ST_IKEY: begin
				if (!sts.busy) state_d = hse_pkg::ST_IDLE;
			end
			hse_pkg::ST_MSGBLK: begin
				cmd.start = 1'b1;
				state_d = hse_pkg::ST_ABSORB;
			end
			hse_pkg::ST_ABSORB: begin
				if (!sts.busy) state_d = last_q ? hse_pkg::ST_PAD : hse_pkg::ST_IDLE;
			end
			hse_pkg::ST_PAD: begin
				cmd.put_pad = 1'b1;
				state_d = (pos >= 6'd56) ? hse_pkg::ST_PAD1 : hse_pkg::ST_LEN;
				if (pos >= 6'd56) cmd.start = 1'b0;
			end
			hse_pkg::ST_PAD1: begin
				if (!sts.busy && !last_q) begin
					cmd.clr_buf = 1'b1;
					state_d = hse_pkg::ST_LEN;
				end else if (last_q) begin
					cmd.start = 1'b1;
					last_d = 1'b0;
				end
			end
			hse_pkg::ST_LEN: begin
				if (!sts.busy) begin
					cmd.put_len = 1'b1;
					state_d = hse_pkg::ST_OKEY;
					last_d = 1'b1;
				end
			end
			hse_pkg::ST_OKEY: begin
				if (!sts.busy) begin
					if (last_q) begin
						cmd.start = 1'b1;
						last_d = 1'b0;
					end else begin
						cmd.save_dig = 1'b1;
						cmd.reset_cv = 1'b1;
						state_d = hse_pkg::ST_OUTER;
					end
				end
			end
			hse_pkg::ST_OUTER: begin
				if (!sts.busy) begin
					if (!last_q) begin
						cmd.start = 1'b1;
						cmd.src = hse_pkg::SRC_OPAD;
						last_d = 1'b1;
					end else begin
						cmd.start = 1'b1;
						cmd.src = hse_pkg::SRC_DIGEST;
						last_d = 1'b0;
						state_d = hse_pkg::ST_EMIT;
					end
				end
			end
			hse_pkg::ST_EMIT: begin
				out_valid = !sts.busy;
				if (!sts.busy && out_ready) begin
					cmd.reset_cv = 1'b1;
					cmd.cnt_clr = 1'b1;
					kdone_d = 1'b0;
					state_d = hse_pkg::ST_IDLE;
				end
			end
			default: state_d = hse_pkg::ST_IDLE;
		endcase
	end

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == hse_pkg::ST_IDLE && kdone_q)
		else $error("input taken before key block");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !sts.busy)
		else $error("result shown during compression");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output at once");

endmodule

// ===== rtl/hmac_sha256_engine.sv =====
// ----------------------------------------------------------------------------
// hmac_sha256_engine
// HMAC-SHA-256 over a byte stream with a key of up to 64 bytes.
// ----------------------------------------------------------------------------
// Input transactions carry one message byte (byte_present) and an end flag
// (last_byte). The key sits in eight 64-bit words written through the cfg
// port; the user must write them only while the block is idle (the block
// does not enforce this). The first transaction of a message waits for the
// ipad key block. Bytes are then accepted one per cycle, but every 64th
// byte starts a compression (64 rounds, one per cycle, in one shared round
// unit) during which no input is accepted. On the last transaction one or
// two padding blocks (the last holding the length), the opad block and the
// digest block follow before the 256-bit MAC is offered on the output
// channel. The MAC is held until taken; while the receiver stalls no input
// is accepted. Reset clears sequencer, byte count, chain value, key words.
// ----------------------------------------------------------------------------
module hmac_sha256_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hse_pkg::in_item_t    in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hse_pkg::out_item_t   out_item,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data
);

	logic [63:0] key_q [hse_pkg::KeyWords];
	logic [511:0] key;
	hse_pkg::dp_cmd_t cmd;
	hse_pkg::dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hse_pkg::KeyWords; i++) key_q[i] <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	assign key = {key_q[0], key_q[1], key_q[2], key_q[3],
		key_q[4], key_q[5], key_q[6], key_q[7]};

	hse_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.out_valid, .out_ready, .sts, .cmd
	);

	hse_datapath u_dp (
		.clk, .arst_n, .cmd, .in_byte(in_item.message_byte), .key, .sts, .mac(out_item)
	);

endmodule
